@@ rtl/vbrs_pkg.sv @@
// ----------------------------------------------------------------------------
// vbrs_pkg: shared types and constants of the verified block range set
// Holds the channel payloads, the range table entry, the register indexes,
// the action codes and the sequencer states.
// ----------------------------------------------------------------------------
package vbrs_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_BYTES  = 2'd1;

	localparam logic [32:0] BLOCK_BYTES_RST = 33'd65536;
	localparam logic [47:0] FILE_BYTES_RST  = 48'd1;

	// action codes
	localparam logic ACT_MARK  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// input transaction
	typedef struct packed {
		logic        action;
		logic [15:0] first_block;
		logic [15:0] past_block;
		logic [47:0] query_pos;
		logic [47:0] query_len;
	} in_t;

	// output transaction
	typedef struct packed {
		logic        is_verified;
		logic [47:0] clipped_len;
		logic        was_duplicate;
		logic        table_full;
		logic [47:0] verified_total;
	} out_t;

	// one range table entry, half-open [start_blk, end_blk)
	typedef struct packed {
		logic        valid;
		logic [15:0] start_blk;
		logic [15:0] end_blk;
	} entry_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_M_SCAN,
		ST_M_COMMIT,
		ST_M_ABS,
		ST_M_MUL,
		ST_M_ADD,
		ST_Q_LO,
		ST_Q_HI,
		ST_Q_LAST,
		ST_Q_FIN,
		ST_RESP
	} state_t;

endpackage

@@ rtl/vbrs_in_if.sv @@
// ----------------------------------------------------------------------------
// vbrs_in_if: input channel
// Valid/ready channel carrying one mark or query transaction.
// ----------------------------------------------------------------------------
interface vbrs_in_if;
	import vbrs_pkg::*;

	logic valid;
	logic ready;
	in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/vbrs_out_if.sv @@
// ----------------------------------------------------------------------------
// vbrs_out_if: output channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface vbrs_out_if;
	import vbrs_pkg::*;

	logic valid;
	logic ready;
	out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/vbrs_ram.sv @@
// ----------------------------------------------------------------------------
// vbrs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vbrs_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/vbrs_mul.sv @@
// ----------------------------------------------------------------------------
// vbrs_mul: shared block-to-byte multiplier
// Multiplies a block count by the block size, product registered.
// ----------------------------------------------------------------------------
module vbrs_mul (
	input  logic        clk,
	input  logic [15:0] blocks,
	input  logic [32:0] block_bytes,
	output logic [48:0] product_q
);
	// one 16 x 33 product per cycle
	always_ff @(posedge clk) begin
		product_q <= {33'd0, blocks} * {16'd0, block_bytes};
	end
endmodule

@@ rtl/verified_block_range_set.sv @@
// ----------------------------------------------------------------------------
// verified_block_range_set: table of verified block ranges
// Marks coalesce block ranges into a table walked entry by entry; queries
// look up a byte position in the table scaled by the block size.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    action, first_block, past_block,
//                                  query_pos, query_len
//   out_ch   out  valid / ready    is_verified, clipped_len, was_duplicate,
//                                  table_full, verified_total
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// A mark reads one table entry per cycle from the single RAM read port,
// then writes the entry and does one multiply-add; absorbing the following
// range adds a state that clears the absorbed entry, and a duplicate or
// full-table mark ends at the commit step without a write.
// A query walks the table too: each entry needs two products on the one
// shared multiplier. Empty marks and zero-length queries skip the table.
// in_ch.ready rises in the cycle after the result is loaded.
// After reset a clearing pass clears every table entry before in_ch.ready.
// A result waits in the output register; the next transaction is accepted
// meanwhile and holds in its final state only if the output is still full.
// ----------------------------------------------------------------------------
module verified_block_range_set #(
	parameter int MAX_RANGES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vbrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vbrs_pkg::CFG_DATA_W-1:0] cfg_data,
	vbrs_in_if.sink                        in_ch,
	vbrs_out_if.source                     out_ch
);
	import vbrs_pkg::*;

	localparam int IDX_W = $clog2(MAX_RANGES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RANGES - 1);

	state_t state_q, state_d;

	// configuration registers
	logic [32:0] block_bytes_q;
	logic [47:0] file_bytes_q;

	// transaction and counters
	in_t         item_q;
	logic [IDX_W-1:0] cnt_q;
	logic        cnt_last;
	logic [47:0] count_q;

	// scan trackers
	logic             hit_q, hit_dup_q;
	logic [15:0]      hit_start_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [47:0]      hit_hi_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             abs_q;
	logic [IDX_W-1:0] abs_idx_q;
	logic [15:0]      abs_end_q;

	// result flags
	logic        res_ver_q, res_dup_q, res_full_q;
	logic [47:0] res_len_q;

	// output register
	logic out_valid_q;
	out_t out_data_q;

	// query pipeline
	entry_t      entry_q;
	logic [48:0] lo_q;

	// ram and multiplier
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;
	logic [15:0]      mul_a;
	logic [48:0]      product;

	logic in_acc;
	logic out_free;

	vbrs_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	vbrs_mul u_mul (
		.clk         (clk),
		.blocks      (mul_a),
		.block_bytes (block_bytes_q),
		.product_q   (product)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign cnt_last    = (cnt_q == LAST_IDX);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// mark scan compare on the entry just read
	logic mk_in, mk_adj, mk_hit, mk_better;
	always_comb begin
		mk_in  = ram_rdata.valid && (item_q.first_block >= ram_rdata.start_blk)
			&& (item_q.first_block < ram_rdata.end_blk);
		mk_adj = ram_rdata.valid && (ram_rdata.end_blk == item_q.first_block);
		mk_hit = mk_in || mk_adj;
		mk_better = mk_hit && (!hit_q || (ram_rdata.start_blk < hit_start_q));
	end

	// query compare on the entry whose two products are ready
	logic [47:0] q_hi;
	logic        q_match, q_better, q_cmp_en;
	always_comb begin
		q_hi = (product > {1'b0, file_bytes_q}) ? file_bytes_q : product[47:0];
		q_match = entry_q.valid && (lo_q <= {1'b0, item_q.query_pos})
			&& (item_q.query_pos < q_hi);
		q_better = q_match && (!hit_q || (entry_q.start_blk < hit_start_q));
		q_cmp_en = ((state_q == ST_Q_LO) && (cnt_q != '0)) || (state_q == ST_Q_LAST);
	end

	// commit decision after the mark scan
	logic             cm_dup, cm_full;
	logic [IDX_W-1:0] cm_idx;
	always_comb begin
		cm_dup  = hit_q && hit_dup_q;
		cm_full = !hit_q && !free_q;
		cm_idx  = hit_q ? hit_idx_q : free_idx_q;
	end

	// saturating count update
	logic [49:0] sum;
	logic [47:0] room;
	assign sum  = {2'b00, count_q} + {1'b0, product};
	assign room = hit_hi_q - item_q.query_pos;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (in_ch.data.action == ACT_MARK) begin
						if (in_ch.data.past_block <= in_ch.data.first_block)
							state_d = ST_RESP;
						else
							state_d = ST_M_SCAN;
					end else begin
						if (in_ch.data.query_len == '0)
							state_d = ST_RESP;
						else
							state_d = ST_Q_LO;
					end
				end
			end
			ST_M_SCAN: begin
				if (cnt_last) state_d = ST_M_COMMIT;
			end
			ST_M_COMMIT: begin
				if (cm_dup || cm_full) state_d = ST_RESP;
				else if (abs_q)       state_d = ST_M_ABS;
				else                  state_d = ST_M_MUL;
			end
			ST_M_ABS:  state_d = ST_M_MUL;
			ST_M_MUL:  state_d = ST_M_ADD;
			ST_M_ADD:  state_d = ST_RESP;
			ST_Q_LO:   state_d = ST_Q_HI;
			ST_Q_HI: begin
				if (cnt_last) state_d = ST_Q_LAST;
				else          state_d = ST_Q_LO;
			end
			ST_Q_LAST: state_d = ST_Q_FIN;
			ST_Q_FIN:  state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// ram and multiplier controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		ram_raddr = '0;
		mul_a     = item_q.past_block - item_q.first_block;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = '0;
			end
			ST_M_SCAN: begin
				ram_raddr = cnt_last ? '0 : cnt_q + 1'b1;
			end
			ST_M_COMMIT: begin
				ram_we              = !(cm_dup || cm_full);
				ram_waddr           = cm_idx;
				ram_wdata.valid     = 1'b1;
				ram_wdata.start_blk = hit_q ? hit_start_q : item_q.first_block;
				ram_wdata.end_blk   = abs_q ? abs_end_q : item_q.past_block;
			end
			ST_M_ABS: begin
				ram_we    = 1'b1;
				ram_waddr = abs_idx_q;
				ram_wdata = '0;
			end
			ST_Q_LO: begin
				mul_a = ram_rdata.start_blk;
			end
			ST_Q_HI: begin
				mul_a     = entry_q.end_blk;
				ram_raddr = cnt_last ? '0 : cnt_q + 1'b1;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BLOCK_BYTES_RST;
			file_bytes_q  <= FILE_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_BYTES: block_bytes_q <= cfg_data[32:0];
				REG_FILE_BYTES:  file_bytes_q  <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	// entry counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR, ST_M_SCAN, ST_Q_HI: cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
				ST_IDLE:                      cnt_q <= '0;
				default: ;
			endcase
		end
	end

	// verified byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_M_ADD) begin
			count_q <= (sum < {2'b00, file_bytes_q}) ? sum[47:0] : file_bytes_q;
		end
	end

	// scan trackers and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			hit_dup_q  <= 1'b0;
			free_q     <= 1'b0;
			abs_q      <= 1'b0;
			res_ver_q  <= 1'b0;
			res_dup_q  <= 1'b0;
			res_full_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						hit_q      <= 1'b0;
						hit_dup_q  <= 1'b0;
						free_q     <= 1'b0;
						abs_q      <= 1'b0;
						res_ver_q  <= 1'b0;
						res_dup_q  <= 1'b0;
						res_full_q <= 1'b0;
					end
				end
				ST_M_SCAN: begin
					if (mk_better) begin
						hit_q     <= 1'b1;
						hit_dup_q <= mk_in;
					end
					if (!ram_rdata.valid && !free_q) free_q <= 1'b1;
					if (ram_rdata.valid && (ram_rdata.start_blk == item_q.past_block))
						abs_q <= 1'b1;
				end
				ST_M_COMMIT: begin
					res_dup_q  <= cm_dup;
					res_full_q <= cm_full;
				end
				ST_Q_LO, ST_Q_LAST: begin
					if (q_cmp_en && q_better) hit_q <= 1'b1;
				end
				ST_Q_FIN: begin
					res_ver_q <= hit_q;
				end
				default: ;
			endcase
		end
	end

	// tracker payloads and query pipeline
	always_ff @(posedge clk) begin
		if (in_acc) item_q <= in_ch.data;
		case (state_q)
			ST_M_SCAN: begin
				if (mk_better) begin
					hit_start_q <= ram_rdata.start_blk;
					hit_idx_q   <= cnt_q;
				end
				if (!ram_rdata.valid && !free_q) free_idx_q <= cnt_q;
				if (ram_rdata.valid && (ram_rdata.start_blk == item_q.past_block)) begin
					abs_idx_q <= cnt_q;
					abs_end_q <= ram_rdata.end_blk;
				end
			end
			ST_Q_LO: begin
				entry_q <= ram_rdata;
				if (q_cmp_en && q_better) begin
					hit_start_q <= entry_q.start_blk;
					hit_hi_q    <= q_hi;
				end
			end
			ST_Q_HI: begin
				lo_q <= product;
			end
			ST_Q_LAST: begin
				if (q_better) begin
					hit_start_q <= entry_q.start_blk;
					hit_hi_q    <= q_hi;
				end
			end
			ST_Q_FIN: begin
				res_len_q <= (item_q.query_len < room) ? item_q.query_len : room;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESP) && out_free) begin
			out_data_q.is_verified    <= res_ver_q;
			out_data_q.clipped_len    <= res_ver_q ? res_len_q : '0;
			out_data_q.was_duplicate  <= res_dup_q;
			out_data_q.table_full     <= res_full_q;
			out_data_q.verified_total <= count_q;
		end
	end
endmodule
